>>> rtl/grid_line_of_sight_core_assert.svh
// Assertion macros used by the checker file of the line of sight core.
`ifndef GRID_LINE_OF_SIGHT_CORE_ASSERT_SVH
`define GRID_LINE_OF_SIGHT_CORE_ASSERT_SVH

// The condition implies the expression at the same clock edge.
`define ASSERT_SAME_CYCLE(name, clk, rst, cond, expr) \
   name: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("line of sight check failed");

// The condition implies the expression at the next clock edge.
`define ASSERT_NEXT_CYCLE(name, clk, rst, cond, expr) \
   name: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("line of sight check failed");

`endif

>>> rtl/glos_pkg.sv
package glos_pkg;

   localparam int COORD_W = 8;
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = 1;

   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_TRACE = 1'b1;

   typedef enum logic [1:0] {
      KIND_WRITE,
      KIND_TRACE,
      KIND_SAME
   } glos_kind_type;

   typedef struct packed {
      glos_kind_type        kind;
      logic [COORD_W-1:0]   start_x;
      logic [COORD_W-1:0]   start_y;
      logic [COORD_W-1:0]   target_x;
      logic [COORD_W-1:0]   target_y;
      logic                 blocks;
      logic                 x_neg;
      logic                 y_neg;
      logic [COORD_W-1:0]   dx_mag;
      logic [COORD_W-1:0]   dy_mag;
      logic [COORD_W-1:0]   steps;
   } glos_item_type;

   typedef struct packed {
      logic          valid;
      glos_item_type item;
   } glos_slot_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DIVIDE,
      ST_SETUP,
      ST_PROBE,
      ST_TEST_SIDE,
      ST_TEST_DIAG,
      ST_RESULT
   } glos_state_type;

endpackage

>>> rtl/glos_front.sv
module glos_front (
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_command,
   input  logic [glos_pkg::COORD_W-1:0]  req_start_x,
   input  logic [glos_pkg::COORD_W-1:0]  req_start_y,
   input  logic [glos_pkg::COORD_W-1:0]  req_target_x,
   input  logic [glos_pkg::COORD_W-1:0]  req_target_y,
   input  logic                          req_blocks,
   input  logic                          queue_full,
   input  logic                          clearing,
   output glos_pkg::glos_slot_type       push
);
   import glos_pkg::*;

   logic               x_neg;
   logic               y_neg;
   logic [COORD_W-1:0] dx_mag;
   logic [COORD_W-1:0] dy_mag;
   logic               same_cell;

   assign req_stall = queue_full || clearing;

   always_comb begin
      x_neg     = req_target_x < req_start_x;
      y_neg     = req_target_y < req_start_y;
      dx_mag    = x_neg ? req_start_x - req_target_x : req_target_x - req_start_x;
      dy_mag    = y_neg ? req_start_y - req_target_y : req_target_y - req_start_y;
      same_cell = (req_start_x == req_target_x) && (req_start_y == req_target_y);

      push.valid         = req_valid && !req_stall;
      push.item.start_x  = req_start_x;
      push.item.start_y  = req_start_y;
      push.item.target_x = req_target_x;
      push.item.target_y = req_target_y;
      push.item.blocks   = req_blocks;
      push.item.x_neg    = x_neg;
      push.item.y_neg    = y_neg;
      push.item.dx_mag   = dx_mag;
      push.item.dy_mag   = dy_mag;
      push.item.steps    = (dx_mag > dy_mag) ? dx_mag : dy_mag;
      if (req_command == CMD_WRITE) begin
         push.item.kind = KIND_WRITE;
      end else if (same_cell) begin
         push.item.kind = KIND_SAME;
      end else begin
         push.item.kind = KIND_TRACE;
      end
   end

endmodule

>>> rtl/glos_queue.sv
module glos_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  glos_pkg::glos_slot_type push,
   output logic                    full,
   output glos_pkg::glos_slot_type head,
   input  logic                    pop
);
   import glos_pkg::*;

   glos_item_type          queue_mem [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff;
   logic [QUEUE_PTR_W-1:0] wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff;
   logic [QUEUE_PTR_W-1:0] rd_ptr_in;
   logic [QUEUE_PTR_W:0]   count_ff;
   logic [QUEUE_PTR_W:0]   count_in;
   logic                   do_push;
   logic                   do_pop;

   always_comb begin
      full       = count_ff == (QUEUE_PTR_W + 1)'(QUEUE_DEPTH);
      head.valid = count_ff != '0;
      head.item  = queue_mem[rd_ptr_ff];
      do_push    = push.valid && !full;
      do_pop     = pop && head.valid;
      wr_ptr_in  = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in  = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in   = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         queue_mem[wr_ptr_ff] <= push.item;
      end
   end

endmodule

>>> rtl/glos_back.sv
module glos_back #(
   parameter int MAP_WIDTH     = 256,
   parameter int MAP_HEIGHT    = 256,
   parameter int FRACTION_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  glos_pkg::glos_slot_type       head,
   output logic                          pop,
   output logic                          clearing,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_visible,
   output logic [glos_pkg::COORD_W-1:0]  rsp_stop_x,
   output logic [glos_pkg::COORD_W-1:0]  rsp_stop_y,
   output logic [glos_pkg::COORD_W-1:0]  rsp_hit_x,
   output logic [glos_pkg::COORD_W-1:0]  rsp_hit_y
);
   import glos_pkg::*;

   localparam int CELL_COUNT = MAP_WIDTH * MAP_HEIGHT;
   localparam int ADDR_W     = $clog2(CELL_COUNT);
   localparam int CNT_W      = $clog2(FRACTION_BITS + 1);
   localparam int QUO_W      = FRACTION_BITS + 1;
   localparam int STEP_W     = FRACTION_BITS + 2;
   localparam int POS_W      = COORD_W + FRACTION_BITS + 1;
   localparam int HALF_CELL  = ((1 << FRACTION_BITS) - 1) / 2;

   function automatic logic in_map(input logic [COORD_W-1:0] x,
                                   input logic [COORD_W-1:0] y);
      return (32'(x) < 32'(MAP_WIDTH)) && (32'(y) < 32'(MAP_HEIGHT));
   endfunction

   function automatic logic [ADDR_W-1:0] cell_addr(input logic [COORD_W-1:0] x,
                                                   input logic [COORD_W-1:0] y);
      logic [31:0] lin;
      lin = 32'(y) * 32'(MAP_WIDTH) + 32'(x);
      return lin[ADDR_W-1:0];
   endfunction

   logic map_mem [CELL_COUNT];

   glos_state_type            state_ff, state_in;
   logic [ADDR_W-1:0]         clear_addr_ff, clear_addr_in;
   glos_item_type             cur_ff, cur_in;
   logic [CNT_W-1:0]          div_cnt_ff, div_cnt_in;
   logic [COORD_W-1:0]        rem_x_ff, rem_x_in, rem_y_ff, rem_y_in;
   logic [QUO_W-1:0]          quo_x_ff, quo_x_in, quo_y_ff, quo_y_in;
   logic signed [STEP_W-1:0]  step_x_ff, step_x_in, step_y_ff, step_y_in;
   logic signed [POS_W-1:0]   pos_x_ff, pos_x_in, pos_y_ff, pos_y_in;
   logic [COORD_W-1:0]        last_x_ff, last_x_in, last_y_ff, last_y_in;
   logic [COORD_W-1:0]        steps_ff, steps_in;
   logic                      rd_a_ff, rd_b_ff;
   logic                      ok_a_ff, ok_a_in, ok_b_ff, ok_b_in;
   logic                      res_visible_ff, res_visible_in;
   logic [COORD_W-1:0]        res_stop_x_ff, res_stop_x_in, res_stop_y_ff, res_stop_y_in;
   logic [COORD_W-1:0]        res_hit_x_ff, res_hit_x_in, res_hit_y_ff, res_hit_y_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      rsp_visible_ff, rsp_visible_in;
   logic [COORD_W-1:0]        rsp_stop_x_ff, rsp_stop_x_in, rsp_stop_y_ff, rsp_stop_y_in;
   logic [COORD_W-1:0]        rsp_hit_x_ff, rsp_hit_x_in, rsp_hit_y_ff, rsp_hit_y_in;

   logic                      wr_en;
   logic [ADDR_W-1:0]         wr_addr;
   logic                      wr_data;
   logic [ADDR_W-1:0]         addr_a;
   logic [ADDR_W-1:0]         addr_b;
   logic [COORD_W-1:0]        nx;
   logic [COORD_W-1:0]        ny;
   logic                      x_moved;
   logic                      y_moved;
   logic                      blk_a;
   logic                      blk_b;
   logic [COORD_W:0]          trial_x, trial_y, diff_x, diff_y;
   logic                      ge_x, ge_y;
   logic signed [STEP_W-1:0]  step_x_new, step_y_new;
   logic signed [POS_W-1:0]   base_x, base_y;

   assign clearing    = state_ff == ST_CLEAR;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_visible = rsp_visible_ff;
   assign rsp_stop_x  = rsp_stop_x_ff;
   assign rsp_stop_y  = rsp_stop_y_ff;
   assign rsp_hit_x   = rsp_hit_x_ff;
   assign rsp_hit_y   = rsp_hit_y_ff;

   always_comb begin
      nx      = pos_x_ff[FRACTION_BITS +: COORD_W];
      ny      = pos_y_ff[FRACTION_BITS +: COORD_W];
      x_moved = nx != last_x_ff;
      y_moved = ny != last_y_ff;
      blk_a   = rd_a_ff && ok_a_ff;
      blk_b   = rd_b_ff && ok_b_ff;

      // One restoring division step per lane, one quotient bit per cycle.
      trial_x = {rem_x_ff, 1'b0};
      trial_y = {rem_y_ff, 1'b0};
      diff_x  = trial_x - {1'b0, cur_ff.steps};
      diff_y  = trial_y - {1'b0, cur_ff.steps};
      ge_x    = trial_x >= {1'b0, cur_ff.steps};
      ge_y    = trial_y >= {1'b0, cur_ff.steps};

      step_x_new = cur_ff.x_neg ? -$signed({1'b0, quo_x_ff}) : $signed({1'b0, quo_x_ff});
      step_y_new = cur_ff.y_neg ? -$signed({1'b0, quo_y_ff}) : $signed({1'b0, quo_y_ff});
      base_x     = $signed({1'b0, cur_ff.start_x, FRACTION_BITS'(HALF_CELL)});
      base_y     = $signed({1'b0, cur_ff.start_y, FRACTION_BITS'(HALF_CELL)});

      state_in       = state_ff;
      clear_addr_in  = clear_addr_ff;
      cur_in         = cur_ff;
      div_cnt_in     = div_cnt_ff;
      rem_x_in       = rem_x_ff;
      rem_y_in       = rem_y_ff;
      quo_x_in       = quo_x_ff;
      quo_y_in       = quo_y_ff;
      step_x_in      = step_x_ff;
      step_y_in      = step_y_ff;
      pos_x_in       = pos_x_ff;
      pos_y_in       = pos_y_ff;
      last_x_in      = last_x_ff;
      last_y_in      = last_y_ff;
      steps_in       = steps_ff;
      res_visible_in = res_visible_ff;
      res_stop_x_in  = res_stop_x_ff;
      res_stop_y_in  = res_stop_y_ff;
      res_hit_x_in   = res_hit_x_ff;
      res_hit_y_in   = res_hit_y_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_visible_in = rsp_visible_ff;
      rsp_stop_x_in  = rsp_stop_x_ff;
      rsp_stop_y_in  = rsp_stop_y_ff;
      rsp_hit_x_in   = rsp_hit_x_ff;
      rsp_hit_y_in   = rsp_hit_y_ff;
      pop            = 1'b0;
      wr_en          = 1'b0;
      wr_addr        = clear_addr_ff;
      wr_data        = 1'b0;
      addr_a         = cell_addr(nx, last_y_ff);
      addr_b         = cell_addr(last_x_ff, ny);
      ok_a_in        = in_map(nx, last_y_ff);
      ok_b_in        = in_map(last_x_ff, ny);

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_CLEAR: begin
            wr_en         = 1'b1;
            clear_addr_in = clear_addr_ff + 1'b1;
            if (clear_addr_ff == ADDR_W'(CELL_COUNT - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (head.valid) begin
               pop    = 1'b1;
               cur_in = head.item;
               case (head.item.kind)
                  KIND_WRITE: begin
                     wr_en   = in_map(head.item.start_x, head.item.start_y);
                     wr_addr = cell_addr(head.item.start_x, head.item.start_y);
                     wr_data = head.item.blocks;
                  end
                  KIND_SAME: begin
                     res_visible_in = 1'b1;
                     res_stop_x_in  = head.item.target_x;
                     res_stop_y_in  = head.item.target_y;
                     res_hit_x_in   = '0;
                     res_hit_y_in   = '0;
                     state_in       = ST_RESULT;
                  end
                  KIND_TRACE: begin
                     // The integer quotient bit is one only when the delta equals the step count.
                     rem_x_in   = (head.item.dx_mag == head.item.steps) ? '0 : head.item.dx_mag;
                     rem_y_in   = (head.item.dy_mag == head.item.steps) ? '0 : head.item.dy_mag;
                     quo_x_in   = QUO_W'(head.item.dx_mag == head.item.steps);
                     quo_y_in   = QUO_W'(head.item.dy_mag == head.item.steps);
                     div_cnt_in = CNT_W'(FRACTION_BITS);
                     state_in   = ST_DIVIDE;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_DIVIDE: begin
            rem_x_in   = ge_x ? diff_x[COORD_W-1:0] : trial_x[COORD_W-1:0];
            rem_y_in   = ge_y ? diff_y[COORD_W-1:0] : trial_y[COORD_W-1:0];
            quo_x_in   = {quo_x_ff[QUO_W-2:0], ge_x};
            quo_y_in   = {quo_y_ff[QUO_W-2:0], ge_y};
            div_cnt_in = div_cnt_ff - 1'b1;
            if (div_cnt_ff == CNT_W'(1)) begin
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            step_x_in = step_x_new;
            step_y_in = step_y_new;
            pos_x_in  = base_x + POS_W'(step_x_new);
            pos_y_in  = base_y + POS_W'(step_y_new);
            last_x_in = cur_ff.start_x;
            last_y_in = cur_ff.start_y;
            steps_in  = cur_ff.steps;
            state_in  = ST_PROBE;
         end
         ST_PROBE: begin
            state_in = ST_TEST_SIDE;
         end
         ST_TEST_SIDE, ST_TEST_DIAG: begin
            if (state_ff == ST_TEST_SIDE && x_moved && blk_a) begin
               res_visible_in = 1'b0;
               res_stop_x_in  = last_x_ff;
               res_stop_y_in  = last_y_ff;
               res_hit_x_in   = nx;
               res_hit_y_in   = last_y_ff;
               state_in       = ST_RESULT;
            end else if (state_ff == ST_TEST_SIDE && y_moved && blk_b) begin
               res_visible_in = 1'b0;
               res_stop_x_in  = last_x_ff;
               res_stop_y_in  = last_y_ff;
               res_hit_x_in   = last_x_ff;
               res_hit_y_in   = ny;
               state_in       = ST_RESULT;
            end else if (state_ff == ST_TEST_SIDE && x_moved && y_moved) begin
               addr_a   = cell_addr(nx, ny);
               ok_a_in  = in_map(nx, ny);
               state_in = ST_TEST_DIAG;
            end else if (state_ff == ST_TEST_DIAG && blk_a) begin
               res_visible_in = 1'b0;
               res_stop_x_in  = last_x_ff;
               res_stop_y_in  = last_y_ff;
               res_hit_x_in   = nx;
               res_hit_y_in   = ny;
               state_in       = ST_RESULT;
            end else begin
               last_x_in = nx;
               last_y_in = ny;
               pos_x_in  = pos_x_ff + POS_W'(step_x_ff);
               pos_y_in  = pos_y_ff + POS_W'(step_y_ff);
               steps_in  = steps_ff - 1'b1;
               if (steps_ff == COORD_W'(1)) begin
                  res_visible_in = 1'b1;
                  res_stop_x_in  = cur_ff.target_x;
                  res_stop_y_in  = cur_ff.target_y;
                  res_hit_x_in   = '0;
                  res_hit_y_in   = '0;
                  state_in       = ST_RESULT;
               end else begin
                  state_in = ST_PROBE;
               end
            end
         end
         ST_RESULT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in   = 1'b1;
               rsp_visible_in = res_visible_ff;
               rsp_stop_x_in  = res_stop_x_ff;
               rsp_stop_y_in  = res_stop_y_ff;
               rsp_hit_x_in   = res_hit_x_ff;
               rsp_hit_y_in   = res_hit_y_ff;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clear_addr_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clear_addr_ff <= clear_addr_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff         <= cur_in;
      div_cnt_ff     <= div_cnt_in;
      rem_x_ff       <= rem_x_in;
      rem_y_ff       <= rem_y_in;
      quo_x_ff       <= quo_x_in;
      quo_y_ff       <= quo_y_in;
      step_x_ff      <= step_x_in;
      step_y_ff      <= step_y_in;
      pos_x_ff       <= pos_x_in;
      pos_y_ff       <= pos_y_in;
      last_x_ff      <= last_x_in;
      last_y_ff      <= last_y_in;
      steps_ff       <= steps_in;
      ok_a_ff        <= ok_a_in;
      ok_b_ff        <= ok_b_in;
      res_visible_ff <= res_visible_in;
      res_stop_x_ff  <= res_stop_x_in;
      res_stop_y_ff  <= res_stop_y_in;
      res_hit_x_ff   <= res_hit_x_in;
      res_hit_y_ff   <= res_hit_y_in;
      rsp_visible_ff <= rsp_visible_in;
      rsp_stop_x_ff  <= rsp_stop_x_in;
      rsp_stop_y_ff  <= rsp_stop_y_in;
      rsp_hit_x_ff   <= rsp_hit_x_in;
      rsp_hit_y_ff   <= rsp_hit_y_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         map_mem[wr_addr] <= wr_data;
      end
      rd_a_ff <= map_mem[addr_a];
      rd_b_ff <= map_mem[addr_b];
   end

endmodule

>>> rtl/grid_line_of_sight_core.sv
// Line of sight tracer over a one-bit blocking map of MAP_WIDTH x MAP_HEIGHT cells. A write
// request (command 0) sets or clears one cell and returns nothing; a trace request (command 1)
// walks from the start cell to the target cell with a fixed-point DDA and returns one response
// with visibility, the last clear cell and the blocking cell. After reset the map is cleared one
// cell per cycle, and req_stall stays high until every cell is clear. Requests are taken into a
// two-entry queue and carried out one at a time. A write is carried out as it leaves the queue.
// A trace first runs the bit-serial step divider, then walks n = max(|dx|, |dy|) grid steps
// through the probe, side-test and, when both coordinates move, diagonal-test states, as set by
// the map reads: the two side cells are read together from the dual-read map memory and the
// diagonal cell in the cycle after. A blocking cell ends the walk early, and a trace whose start
// equals its target skips the divider and the walk. The response is held in an output register,
// so the engine goes on with the next request while a finished response waits on rsp_stall.
module grid_line_of_sight_core #(
   parameter int MAP_WIDTH     = 256,
   parameter int MAP_HEIGHT    = 256,
   parameter int FRACTION_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_command,
   input  logic [glos_pkg::COORD_W-1:0]  req_start_x,
   input  logic [glos_pkg::COORD_W-1:0]  req_start_y,
   input  logic [glos_pkg::COORD_W-1:0]  req_target_x,
   input  logic [glos_pkg::COORD_W-1:0]  req_target_y,
   input  logic                          req_blocks,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_visible,
   output logic [glos_pkg::COORD_W-1:0]  rsp_stop_x,
   output logic [glos_pkg::COORD_W-1:0]  rsp_stop_y,
   output logic [glos_pkg::COORD_W-1:0]  rsp_hit_x,
   output logic [glos_pkg::COORD_W-1:0]  rsp_hit_y
);
   import glos_pkg::*;

   glos_slot_type push;
   glos_slot_type head;
   logic          queue_full;
   logic          pop;
   logic          clearing;

   glos_front u_front (
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_command  (req_command),
      .req_start_x  (req_start_x),
      .req_start_y  (req_start_y),
      .req_target_x (req_target_x),
      .req_target_y (req_target_y),
      .req_blocks   (req_blocks),
      .queue_full   (queue_full),
      .clearing     (clearing),
      .push         (push)
   );

   glos_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .full  (queue_full),
      .head  (head),
      .pop   (pop)
   );

   glos_back #(
      .MAP_WIDTH     (MAP_WIDTH),
      .MAP_HEIGHT    (MAP_HEIGHT),
      .FRACTION_BITS (FRACTION_BITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .head        (head),
      .pop         (pop),
      .clearing    (clearing),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_visible (rsp_visible),
      .rsp_stop_x  (rsp_stop_x),
      .rsp_stop_y  (rsp_stop_y),
      .rsp_hit_x   (rsp_hit_x),
      .rsp_hit_y   (rsp_hit_y)
   );

endmodule

>>> rtl/glos_checker.sv
`include "grid_line_of_sight_core_assert.svh"

module glos_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_stall,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic                          rsp_visible,
   input logic [glos_pkg::COORD_W-1:0]  rsp_stop_x,
   input logic [glos_pkg::COORD_W-1:0]  rsp_stop_y,
   input logic [glos_pkg::COORD_W-1:0]  rsp_hit_x,
   input logic [glos_pkg::COORD_W-1:0]  rsp_hit_y
);
   import glos_pkg::*;

   // A stalled response stays offered and unchanged.
   `ASSERT_NEXT_CYCLE(a_rsp_held, clock, reset, rsp_valid && rsp_stall, rsp_valid)
   `ASSERT_NEXT_CYCLE(a_rsp_stable, clock, reset, rsp_valid && rsp_stall, $stable(rsp_visible) && $stable(rsp_stop_x) && $stable(rsp_stop_y) && $stable(rsp_hit_x) && $stable(rsp_hit_y))

   // A visible response carries no hit cell, and a blocked one names a hit cell other than the stop cell.
   `ASSERT_SAME_CYCLE(a_visible_no_hit, clock, reset, rsp_valid && rsp_visible, (rsp_hit_x == '0) && (rsp_hit_y == '0))
   `ASSERT_SAME_CYCLE(a_hit_differs, clock, reset, rsp_valid && !rsp_visible, (rsp_hit_x != rsp_stop_x) || (rsp_hit_y != rsp_stop_y))

   // The map is being cleared right after reset, so no request is taken.
   `ASSERT_SAME_CYCLE(a_clear_after_reset, clock, reset, $past(reset), req_stall)

endmodule

bind grid_line_of_sight_core glos_checker u_glos_checker (
   .clock       (clock),
   .reset       (reset),
   .req_stall   (req_stall),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_visible (rsp_visible),
   .rsp_stop_x  (rsp_stop_x),
   .rsp_stop_y  (rsp_stop_y),
   .rsp_hit_x   (rsp_hit_x),
   .rsp_hit_y   (rsp_hit_y)
);
